[design/span_tracker_unit_macros.svh]
// Assertion macros shared by the span tracker RTL.
`ifndef SPAN_TRACKER_UNIT_MACROS_SVH
`define SPAN_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/sptrk_pkg.sv]
// Package with shared widths, codes and types of the span tracker.
`timescale 1ns / 1ps
package sptrk_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 11;
    localparam int COUNT_OUT_W     = 11;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 80;
    localparam int OUT_TUSER_W     = 1;

    // status codes carried in tuser
    localparam logic ST_STORED = 1'b0;
    localparam logic ST_FULL   = 1'b1;

    // result of the shared gap unit
    typedef struct packed {
        logic [DATA_W-1:0] diff;     // |a - b|
        logic              lt_ref;   // diff below the reference gap
    } t_gap_res;

endpackage

[design/sptrk_mem.sv]
// Value store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module sptrk_mem
    import sptrk_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [MAX_ENTRIES];
    logic signed [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sptrk_gap_unit.sv]
// Shared gap unit: absolute difference of two signed words and compare to a reference.
`timescale 1ns / 1ps
module sptrk_gap_unit
    import sptrk_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic        [DATA_W-1:0] i_ref,
    output t_gap_res                 o_res
);

    logic              a_gt_b;
    logic [DATA_W-1:0] diff;

    // the difference always fits in DATA_W bits as unsigned
    assign a_gt_b = (i_a > i_b);
    assign diff   = a_gt_b ? DATA_W'(i_a - i_b) : DATA_W'(i_b - i_a);

    assign o_res.diff   = diff;
    assign o_res.lt_ref = (diff < i_ref);

endmodule

[design/span_tracker_unit.sv]
// Span tracker top level: sequencer, value store and shared gap unit.
`timescale 1ns / 1ps
// Span tracker.
// Input stream (s_axis): one signed 32-bit value per word in tdata[31:0].
// Output stream (m_axis): one result word per input word. tuser[0] is the
// status (0 stored, 1 rejected, set full). tdata holds count, span_valid,
// longest_span and shortest_span.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the capacity
// register; write it only while no word is in flight.
// Sequence: a stored word passes through S_SCAN, where each held value is
// read from the store and compared with the new one, then S_LAST, which
// writes the value and updates the range, then S_FIN, which forms the
// result. A rejected word goes from S_SCAN straight to S_FIN. The one read
// port of the store and the single gap unit are used once per held value,
// so the held values are handled one at a time.
// s_axis_tready is high only while idle, one word is processed at a time;
// it returns in the cycle after the result is taken.
// Reset clears count, range, closest gap (to all ones) and capacity (to 0,
// so every word is rejected until configured). The store is not cleared.
// While m_axis_tready is low the result stays on the port and no new
// input word is accepted.
module span_tracker_unit
    import sptrk_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_W-1:0]       i_cfg_wr_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [10:0] count, [11] span_valid, [43:12] longest_span,
    // [75:44] shortest_span, [79:76] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] status
);

    `include "span_tracker_unit_macros.svh"

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PAD_W = OUT_TDATA_W - COUNT_OUT_W - 1 - 2 * DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIN,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [CAP_W-1:0]         r_capacity;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic                     r_full;
    logic                     r_rdv;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic [DATA_W-1:0]        r_closest;
    logic                     r_m_valid;
    logic [OUT_TDATA_W-1:0]   r_m_data;
    logic [OUT_TUSER_W-1:0]   r_m_user;

    logic [LW-1:0]            cap_ext;
    logic [LW-1:0]            limit;
    logic                     set_full;
    logic                     in_accept;
    logic                     rd_en;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] gap_a;
    logic signed [DATA_W-1:0] gap_b;
    t_gap_res                 gap_res;
    logic                     span_ok;

    // effective capacity, saturated to the store depth
    assign cap_ext  = LW'(r_capacity);
    assign limit    = (cap_ext < LW'(MAX_ENTRIES)) ? cap_ext : LW'(MAX_ENTRIES);
    assign set_full = (LW'(r_count) >= limit);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // one read per held value during the scan
    assign rd_en = (r_state == S_SCAN) && !r_full && (r_idx < r_count);

    sptrk_mem #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (r_state == S_LAST),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(r_val),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // gap unit: new value vs stored value while scanning, max vs min at the end
    assign gap_a = (r_state == S_FIN) ? r_max : r_val;
    assign gap_b = (r_state == S_FIN) ? r_min : rd_data;

    sptrk_gap_unit u_gap (
        .i_a  (gap_a),
        .i_b  (gap_b),
        .i_ref(r_closest),
        .o_res(gap_res)
    );

    assign span_ok = (r_count >= CW'(2));

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_full    <= 1'b0;
            r_rdv     <= 1'b0;
            r_min     <= '0;
            r_max     <= '0;
            r_closest <= '1;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_val   <= $signed(s_axis_tdata[DATA_W-1:0]);
                        r_full  <= set_full;
                        r_idx   <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // fold in the stored value read last cycle
                    if (r_rdv && gap_res.lt_ref) begin
                        r_closest <= gap_res.diff;
                    end
                    r_rdv <= rd_en;
                    if (r_full) begin
                        r_state <= S_FIN;
                    end else if (rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    // last pending compare, store the value, update the range
                    if (r_rdv && gap_res.lt_ref) begin
                        r_closest <= gap_res.diff;
                    end
                    r_rdv <= 1'b0;
                    if (r_count == '0) begin
                        r_min <= r_val;
                        r_max <= r_val;
                    end else begin
                        if (r_val < r_min) begin
                            r_min <= r_val;
                        end
                        if (r_val > r_max) begin
                            r_max <= r_val;
                        end
                    end
                    r_count <= r_count + CW'(1);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_m_user  <= OUT_TUSER_W'(r_full ? ST_FULL : ST_STORED);
                    r_m_data  <= {PAD_W'(0),
                                  span_ok ? r_closest : DATA_W'(0),
                                  span_ok ? gap_res.diff : DATA_W'(0),
                                  span_ok,
                                  COUNT_OUT_W'(r_count)};
                    r_m_valid <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // checks
    `STU_ASSERT_NOW(a_one_in_flight, s_axis_tready, !m_axis_tvalid,
        "input ready while a result is pending")
    `STU_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_ENTRIES),
        "held count beyond store depth")
    `STU_ASSERT_NEXT(a_store_increments, i_rst_n && r_state == S_LAST,
        r_count == $past(r_count) + CW'(1), "store did not advance count")
    `STU_ASSERT_NEXT(a_gap_never_rises,
        i_rst_n && (r_state == S_SCAN || r_state == S_LAST),
        r_closest <= $past(r_closest), "closest gap increased")
    `STU_ASSERT_NOW(a_spans_zero_when_invalid, m_axis_tvalid && !m_axis_tdata[11],
        m_axis_tdata[75:12] == '0, "spans nonzero without a valid span")

endmodule

[test/tb_span_tracker_unit.sv]
// Testbench for the span tracker: queued stimulus, in-bench prediction, result scoreboard.
`timescale 1ns / 1ps
module tb_span_tracker_unit;
    import sptrk_pkg::*;

    localparam int HOLD_MAX       = MAX_ENTRIES_DEF;
    localparam int FILL_TARGET    = 520;            // stored values the random phases build up
    localparam int CAP_TOP        = (1 << CAP_W) - 1;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 3;
    localparam int TAIL_CYCLES    = HOLD_MAX + 8;   // longest accept-to-result path plus margin
    // Filling to FILL_TARGET dominates the run time, since each word scans
    // every held value; the limit leaves wide room for that and for stalls.
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef enum logic [1:0] {OP_WORD, OP_CAP_WRITE, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic [31:0] payload;
    } t_stim_op;

    typedef struct {
        logic                   status;
        logic [COUNT_OUT_W-1:0] count;
        logic                   span_valid;
        logic [DATA_W-1:0]      longest;
        logic [DATA_W-1:0]      shortest;
    } t_span_report;

    // DUT ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;     // [31:0] value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [10:0] count, [11] span_valid, [43:12] longest_span, [75:44] shortest_span
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;            // [0] status

    // predicted state of the set
    logic signed [DATA_W-1:0] model_vals [HOLD_MAX];
    int unsigned              model_count = 0;
    logic signed [DATA_W-1:0] model_min   = '0;
    logic signed [DATA_W-1:0] model_max   = '0;
    logic [DATA_W-1:0]        model_gap   = '1;
    logic [CAP_W-1:0]         model_cap   = '0;

    // stimulus plan and expected results
    t_stim_op          stim_q[$];
    t_span_report      span_expect_q[$];
    logic [DATA_W-1:0] gen_vals[$];
    int                gen_count   = 0;
    int                gen_cap     = 0;

    int     total_words  = 0;
    int     words_sent   = 0;
    int     stored_seen  = 0;
    int     full_seen    = 0;
    int     cap_writes   = 0;
    int     quiet_cycles = 0;
    int     reset_cnt    = 0;
    int     error_count  = 0;
    longint cycle_count  = 0;

    span_tracker_unit #(
        .MAX_ENTRIES(HOLD_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // reset held low for the first cycles only
    always @(posedge i_clk) begin
        if (reset_cnt < RESET_CYCLES) begin
            reset_cnt <= reset_cnt + 1;
        end
        i_rst_n <= (reset_cnt >= RESET_CYCLES - 1);
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d of %0d words sent",
                   cycle_count, words_sent, total_words);
            $display("Test completed with failures");
            $finish;
        end
    end

    // distance between two signed values, always fits in 32 bits
    function automatic logic [DATA_W-1:0] abs_diff(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
        longint da;
        longint db;
        longint d;
        da = a;
        db = b;
        d = (da > db) ? da - db : db - da;
        return d[DATA_W-1:0];
    endfunction

    // apply one word to the predicted set and form its result
    function automatic t_span_report predict_span(input logic [DATA_W-1:0] word);
        t_span_report             r;
        logic signed [DATA_W-1:0] v;
        logic [DATA_W-1:0]        g;
        int unsigned              room;
        int unsigned              i;
        v = word;
        room = (model_cap < HOLD_MAX) ? model_cap : HOLD_MAX;
        r.status = ST_STORED;
        if (model_count >= room) begin
            r.status = ST_FULL;
        end else begin
            for (i = 0; i < model_count; i++) begin
                g = abs_diff(v, model_vals[i]);
                if (g < model_gap) model_gap = g;
            end
            if (model_count == 0) begin
                model_min = v;
                model_max = v;
            end else begin
                if (v < model_min) model_min = v;
                if (v > model_max) model_max = v;
            end
            model_vals[model_count] = v;
            model_count++;
        end
        r.count      = model_count[COUNT_OUT_W-1:0];
        r.span_valid = (model_count >= 2);
        r.longest    = r.span_valid ? abs_diff(model_max, model_min) : '0;
        r.shortest   = r.span_valid ? model_gap : '0;
        return r;
    endfunction

    // idle pattern: sender light/receiver heavy, then swapped, then none
    function automatic int idle_phase();
        if (words_sent * 3 < total_words) return 0;
        if (words_sent * 3 < total_words * 2) return 1;
        return 2;
    endfunction

    function automatic int send_idle_pct();
        case (idle_phase())
            0:       return 23;
            1:       return 79;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_phase())
            0:       return 79;
            1:       return 23;
            default: return 0;
        endcase
    endfunction

    // plan helpers; gen_* tracks what the set will hold
    task automatic queue_word(input logic [31:0] v);
        t_stim_op op;
        int       room;
        op.kind    = OP_WORD;
        op.payload = v;
        stim_q.insert(stim_q.size(), op);
        total_words++;
        room = (gen_cap < HOLD_MAX) ? gen_cap : HOLD_MAX;
        if (gen_count < room) begin
            gen_vals.insert(gen_vals.size(), v);
            gen_count++;
        end
    endtask

    task automatic queue_cap(input int c);
        t_stim_op op;
        op.kind    = OP_CAP_WRITE;
        op.payload = c;
        stim_q.insert(stim_q.size(), op);
        gen_cap = c;
    endtask

    task automatic queue_drain();
        t_stim_op op;
        op.kind    = OP_DRAIN;
        op.payload = '0;
        stim_q.insert(stim_q.size(), op);
    endtask

    // mostly full-range values, some close to a held one to pull the gap down
    function automatic logic [31:0] rand_value();
        int          sel;
        int          idx;
        logic [31:0] offs;
        sel = $urandom_range(0, 7);
        if (sel < 5 || gen_vals.size() == 0) return $urandom;
        idx  = $urandom_range(0, gen_vals.size() - 1);
        offs = $urandom_range(1, 4095);
        return $urandom_range(0, 1) ? gen_vals[idx] + offs : gen_vals[idx] - offs;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // input side: words, capacity writes and drain pauses from the plan
    always @(posedge i_clk) begin : word_driver
        logic                  nxt_valid;
        logic [IN_TDATA_W-1:0] nxt_data;
        logic                  nxt_cfg_en;
        logic [CAP_W-1:0]      nxt_cfg_data;
        nxt_valid    = s_axis_tvalid;
        nxt_data     = s_axis_tdata;
        nxt_cfg_en   = 1'b0;
        nxt_cfg_data = i_cfg_wr_data;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                span_expect_q.insert(span_expect_q.size(), predict_span(s_axis_tdata));
                words_sent++;
                nxt_valid = 1'b0;
            end
            if (span_expect_q.size() == 0 && !nxt_valid) quiet_cycles++;
            else quiet_cycles = 0;
            if (!nxt_valid && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    OP_WORD: begin
                        if ($urandom_range(0, 99) >= send_idle_pct()) begin
                            nxt_valid = 1'b1;
                            nxt_data  = stim_q[0].payload;
                            void'(stim_q.pop_front());
                        end
                    end
                    OP_CAP_WRITE: begin
                        // only with nothing in flight
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nxt_cfg_en   = 1'b1;
                            nxt_cfg_data = stim_q[0].payload[CAP_W-1:0];
                            model_cap    = nxt_cfg_data;
                            cap_writes++;
                            quiet_cycles = 0;
                            void'(stim_q.pop_front());
                        end
                    end
                    OP_DRAIN: begin
                        if (quiet_cycles >= SETTLE_CYCLES) void'(stim_q.pop_front());
                    end
                    default: ;
                endcase
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
        i_cfg_wr_en   <= nxt_cfg_en;
        i_cfg_wr_data <= nxt_cfg_data;
    end

    // output side: random back-pressure and field-by-field compare
    always @(posedge i_clk) begin : result_monitor
        t_span_report exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (span_expect_q.size() == 0) begin
                $error("result word with nothing expected: tdata=0x%0h", m_axis_tdata);
                error_count++;
            end else begin
                exp_r = span_expect_q.pop_front();
                check_field("status", exp_r.status, m_axis_tuser[0]);
                check_field("count", exp_r.count, m_axis_tdata[10:0]);
                check_field("span_valid", exp_r.span_valid, m_axis_tdata[11]);
                check_field("longest_span", exp_r.longest, m_axis_tdata[43:12]);
                check_field("shortest_span", exp_r.shortest, m_axis_tdata[75:44]);
                check_field("tdata_pad", '0, m_axis_tdata[79:76]);
                if (exp_r.status == ST_FULL) full_seen++;
                else stored_seen++;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // plan the run, then wait for it to drain
    initial begin : stimulus_plan
        int sel;
        int cap;
        int n;
        int k;

        // capacity still at its reset value: everything turned away
        queue_word(32'h8000_0000);
        queue_word(32'h7FFF_FFFF);
        queue_word(32'h0000_0000);
        // single entry: no span yet
        queue_cap(1);
        queue_word(32'd5);
        queue_word(32'hFFFF_FFF9);
        // first spans
        queue_cap(3);
        queue_word(32'hFFFF_FFF9);
        queue_word(32'd100);
        queue_drain();
        queue_word(32'd1);
        // capacity zero and capacity below the count
        queue_cap(0);
        queue_word(32'hFFFF_FFFF);
        queue_cap(2);
        queue_word(32'd2);
        // capacity above storage size
        queue_cap(CAP_TOP);
        queue_word(32'h5555_5555);
        queue_word(32'hAAAA_AAAA);

        // random phases, growing the set
        while (gen_count < FILL_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                cap = $urandom_range(0, gen_count);
                n   = $urandom_range(1, 4);
            end else if (sel == 1) begin
                cap = $urandom_range(HOLD_MAX + 1, CAP_TOP);
                n   = $urandom_range(4, 40);
            end else begin
                cap = gen_count + $urandom_range(1, 40);
                n   = cap - gen_count + $urandom_range(0, 3);
            end
            queue_cap(cap);
            for (k = 0; k < n && gen_count < FILL_TARGET; k++) begin
                if ($urandom_range(0, 59) == 0) queue_drain();
                queue_word(rand_value());
            end
        end

        // closing words: widest span, a repeated value, then capacity at the store depth and capacity zero
        queue_cap(CAP_TOP);
        queue_word(32'h8000_0000);
        queue_word(32'h7FFF_FFFF);
        queue_word(gen_vals[0]);
        queue_word(rand_value());
        queue_word(rand_value());
        queue_word(32'h1234_5678);
        queue_cap(HOLD_MAX);
        queue_word($urandom);
        queue_cap(0);
        queue_word($urandom);

        while (!i_rst_n) @(posedge i_clk);
        while (words_sent != total_words || span_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (span_expect_q.size() != 0) begin
            $error("%0d results never arrived", span_expect_q.size());
            error_count++;
        end

        $display("Run covered %0d words: %0d stored, %0d turned away, %0d capacity writes",
                 total_words, stored_seen, full_seen, cap_writes);
        $display("Set ended at %0d of %0d entries after %0d cycles",
                 model_count, HOLD_MAX, cycle_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
